FILE: rtl/pfa_pkg.sv
// shared types and constants of the prime field arithmetic unit
`timescale 1ns / 1ps

package pfa_pkg;

    // fixed field widths
    localparam int ACT_BITS = 3;
    localparam int EXP_BITS = 63;

    // modulus after reset
    localparam logic [63:0] MOD_RESET_VALUE = 64'd998244353;

    // action codes, the codes five to seven mean nothing
    typedef enum logic [ACT_BITS-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_POW = 3'd3,
        ACT_INV = 3'd4
    } action_t;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE     = 9'b0_0000_0001,
        ST_RED_A    = 9'b0_0000_0010,
        ST_RED_B    = 9'b0_0000_0100,
        ST_DISPATCH = 9'b0_0000_1000,
        ST_MUL_AB   = 9'b0_0001_0000,
        ST_POW_TEST = 9'b0_0010_0000,
        ST_MUL_RES  = 9'b0_0100_0000,
        ST_MUL_SQ   = 9'b0_1000_0000,
        ST_DONE     = 9'b1_0000_0000
    } seq_state_t;

    // control of one modular step: double the accumulator, add the addend
    typedef struct packed {
        logic dbl;
        logic add_en;
    } step_ctrl_t;

endpackage

FILE: rtl/pfa_modstep.sv
// shared modular step unit: (2*acc or acc) plus optional addend, reduced mod m
`timescale 1ns / 1ps

module pfa_modstep #(
    parameter int MOD_BITS = 31
) (
    input  logic [MOD_BITS-1:0] acc,
    input  logic [MOD_BITS-1:0] addend,
    input  logic [MOD_BITS-1:0] modulus,
    input  pfa_pkg::step_ctrl_t ctrl,
    output logic [MOD_BITS-1:0] result
);
    import pfa_pkg::*;

    logic [MOD_BITS:0] mod_ext;
    logic [MOD_BITS:0] dbl_val;
    logic [MOD_BITS:0] dbl_red;
    logic [MOD_BITS:0] sum_val;
    logic [MOD_BITS:0] sum_red;

    assign mod_ext = {1'b0, modulus};

    // optional doubling, then one conditional subtract
    always_comb begin
        dbl_val = ctrl.dbl ? {acc, 1'b0} : {1'b0, acc};
        dbl_red = (dbl_val >= mod_ext) ? dbl_val - mod_ext : dbl_val;
    end

    // optional add, then one conditional subtract
    always_comb begin
        sum_val = dbl_red + (ctrl.add_en ? {1'b0, addend} : '0);
        sum_red = (sum_val >= mod_ext) ? sum_val - mod_ext : sum_val;
    end

    assign result = sum_red[MOD_BITS-1:0];

endmodule

FILE: rtl/pfa_seq.sv
// sequencer and operand registers driving the shared modular step unit
`timescale 1ns / 1ps

module pfa_seq #(
    parameter int MOD_BITS = 31
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pfa_pkg::ACT_BITS-1:0]       s_action,
    input  logic [MOD_BITS-1:0]                s_operand_a,
    input  logic [MOD_BITS-1:0]                s_operand_b,
    input  logic [pfa_pkg::EXP_BITS-1:0]       s_exponent,
    input  logic [MOD_BITS-1:0]                modulus,
    output logic [MOD_BITS-1:0]                step_acc,
    output logic [MOD_BITS-1:0]                step_addend,
    output pfa_pkg::step_ctrl_t                step_ctrl,
    input  logic [MOD_BITS-1:0]                step_result,
    output logic                               done_valid,
    output logic [MOD_BITS-1:0]                done_result,
    input  logic                               out_free
);
    import pfa_pkg::*;

    localparam int CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS - 1);

    seq_state_t             state_reg, state_next;
    action_t                act_reg, act_next;
    logic [MOD_BITS-1:0]    a_reg, a_next;
    logic [MOD_BITS-1:0]    b_reg, b_next;
    logic [MOD_BITS-1:0]    res_reg, res_next;
    logic [EXP_BITS-1:0]    e_reg, e_next;
    logic [MOD_BITS-1:0]    mc_reg, mc_next;
    logic [MOD_BITS-1:0]    ml_reg, ml_next;
    logic [MOD_BITS-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   loop_last;
    logic                   mod_ok;
    logic [MOD_BITS-1:0]    mod_minus_b;

    assign loop_last   = (cnt_reg == '0);
    assign mod_ok      = (modulus >= MOD_BITS'(2));
    assign mod_minus_b = modulus - b_reg;
    assign s_ready     = (state_reg == ST_IDLE);
    assign done_valid  = (state_reg == ST_DONE);
    assign done_result = res_reg;

    // step unit operands: bit-serial loop, or a single add in dispatch
    always_comb begin
        step_acc       = p_reg;
        step_addend    = mc_reg;
        step_ctrl.dbl  = 1'b1;
        step_ctrl.add_en = ml_reg[MOD_BITS-1];
        if (state_reg == ST_DISPATCH) begin
            step_acc         = a_reg;
            step_addend      = (act_reg == ACT_SUB) ? mod_minus_b : b_reg;
            step_ctrl.dbl    = 1'b0;
            step_ctrl.add_en = 1'b1;
        end
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        e_next     = e_reg;
        mc_next    = mc_reg;
        ml_next    = ml_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next = action_t'(s_action);
                    b_next   = s_operand_b;
                    e_next   = s_exponent;
                    // reduce operand a: shift its bits in, addend one
                    ml_next  = s_operand_a;
                    mc_next  = MOD_BITS'(1);
                    p_next   = '0;
                    cnt_next = CNT_LAST;
                    res_next = '0;
                    state_next = mod_ok ? ST_RED_A : ST_DONE;
                end
            end
            ST_RED_A: begin
                p_next   = step_result;
                ml_next  = ml_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (loop_last) begin
                    a_next   = step_result;
                    ml_next  = b_reg;
                    p_next   = '0;
                    cnt_next = CNT_LAST;
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B: begin
                p_next   = step_result;
                ml_next  = ml_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (loop_last) begin
                    b_next     = step_result;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (act_reg)
                    ACT_ADD, ACT_SUB: begin
                        res_next   = step_result;
                        state_next = ST_DONE;
                    end
                    ACT_MUL: begin
                        mc_next  = a_reg;
                        ml_next  = b_reg;
                        p_next   = '0;
                        cnt_next = CNT_LAST;
                        state_next = ST_MUL_AB;
                    end
                    ACT_POW: begin
                        res_next   = MOD_BITS'(1);
                        state_next = ST_POW_TEST;
                    end
                    ACT_INV: begin
                        if (a_reg == '0) begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end else begin
                            res_next   = MOD_BITS'(1);
                            e_next     = EXP_BITS'(modulus - MOD_BITS'(2));
                            state_next = ST_POW_TEST;
                        end
                    end
                    default: begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MUL_AB: begin
                p_next   = step_result;
                ml_next  = ml_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (loop_last) begin
                    res_next   = step_result;
                    state_next = ST_DONE;
                end
            end
            ST_POW_TEST: begin
                p_next   = '0;
                cnt_next = CNT_LAST;
                mc_next  = a_reg;
                if (e_reg == '0) begin
                    state_next = ST_DONE;
                end else if (e_reg[0]) begin
                    ml_next    = res_reg;
                    state_next = ST_MUL_RES;
                end else begin
                    ml_next    = a_reg;
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_RES: begin
                p_next   = step_result;
                ml_next  = ml_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (loop_last) begin
                    res_next = step_result;
                    if (e_reg[EXP_BITS-1:1] == '0) begin
                        // last exponent bit, the square is not needed
                        state_next = ST_DONE;
                    end else begin
                        mc_next  = a_reg;
                        ml_next  = a_reg;
                        p_next   = '0;
                        cnt_next = CNT_LAST;
                        state_next = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_SQ: begin
                p_next   = step_result;
                ml_next  = ml_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (loop_last) begin
                    a_next     = step_result;
                    e_next     = e_reg >> 1;
                    state_next = ST_POW_TEST;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // operand and loop registers
    always_ff @(posedge aclk) begin
        act_reg <= act_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        res_reg <= res_next;
        e_reg   <= e_next;
        mc_reg  <= mc_next;
        ml_reg  <= ml_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
    end

endmodule

FILE: rtl/prime_field_alu.sv
// top level of the prime field arithmetic unit
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | s_valid / s_ready      | s_action, s_operand_a, s_operand_b,
//           |                        | s_exponent
//  result   | m_valid / m_ready      | m_result
//  config   | cfg_valid / cfg_ready  | cfg_modulus
//
// every multiply is bit serial on one modular step unit.
// both operands are first reduced mod the modulus bit serially; then add/sub finish in
// dispatch, multiply runs one multiply; power and inverse pass dispatch, then for each
// exponent bit up to the top set bit test it, multiply the result in when the bit is
// set and square the base, the top bit skipping its square.
// s_ready is high only in idle; one transaction is in work at a time.
// a finished result sits in an output register; the unit waits if it is taken late.
// synchronous active-low reset loads the modulus with 998244353.
`timescale 1ns / 1ps

module prime_field_alu #(
    parameter int MOD_BITS = 31
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pfa_pkg::ACT_BITS-1:0]   s_action,
    input  logic [MOD_BITS-1:0]            s_operand_a,
    input  logic [MOD_BITS-1:0]            s_operand_b,
    input  logic [pfa_pkg::EXP_BITS-1:0]   s_exponent,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [MOD_BITS-1:0]            m_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [MOD_BITS-1:0]            cfg_modulus
);
    import pfa_pkg::*;

    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(MOD_RESET_VALUE);

    logic [MOD_BITS-1:0] modulus_reg;
    logic                m_valid_reg;
    logic [MOD_BITS-1:0] m_result_reg;

    logic [MOD_BITS-1:0] step_acc;
    logic [MOD_BITS-1:0] step_addend;
    step_ctrl_t          step_ctrl;
    logic [MOD_BITS-1:0] step_result;
    logic                done_valid;
    logic [MOD_BITS-1:0] done_result;
    logic                out_free;

    // modulus register, writable at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            modulus_reg <= cfg_modulus;
        end
    end

    // sequencer
    pfa_seq #(
        .MOD_BITS (MOD_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_exponent  (s_exponent),
        .modulus     (modulus_reg),
        .step_acc    (step_acc),
        .step_addend (step_addend),
        .step_ctrl   (step_ctrl),
        .step_result (step_result),
        .done_valid  (done_valid),
        .done_result (done_result),
        .out_free    (out_free)
    );

    // shared modular step unit
    pfa_modstep #(
        .MOD_BITS (MOD_BITS)
    ) u_modstep (
        .acc     (step_acc),
        .addend  (step_addend),
        .modulus (modulus_reg),
        .ctrl    (step_ctrl),
        .result  (step_result)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && out_free) begin
            m_result_reg <= done_result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // results stay inside the field
    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result < modulus_reg) || (modulus_reg < MOD_BITS'(2)))
        else $error("result not reduced below modulus");

    // an accepted transaction keeps the unit busy for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous transaction in work");

    // a new result is only loaded when the previous one has been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("pending result overwritten");

endmodule
